@@ hw/rtl/a64dec_pkg.sv @@
// ----------------------------------------------------------------------------
// a64dec_pkg
// Types and constants shared by the AArch64 subset decoder.
// ----------------------------------------------------------------------------
package a64dec_pkg;

	typedef enum logic [3:0] {
		ALU_NONE = 4'd0,
		ALU_AND  = 4'd1,
		ALU_OR   = 4'd2,
		ALU_ADD  = 4'd3,
		ALU_MUL  = 4'd4,
		ALU_XOR  = 4'd5,
		ALU_SUB  = 4'd6,
		ALU_TSTZ = 4'd7,
		ALU_MOV  = 4'd8,
		ALU_LSL  = 4'd9,
		ALU_LSR  = 4'd10
	} alu_op_t;

	// bit positions in the control flag word
	localparam int unsigned F_BTBHIT   = 0;
	localparam int unsigned F_IMMSRC   = 1;
	localparam int unsigned F_REGW     = 2;
	localparam int unsigned F_SETFLAGS = 3;
	localparam int unsigned F_HALT     = 4;
	localparam int unsigned F_UB       = 5;
	localparam int unsigned F_PCREG    = 6;
	localparam int unsigned F_CB       = 7;
	localparam int unsigned F_ALUZERO  = 8;
	localparam int unsigned F_B2DEST   = 9;
	localparam int unsigned F_CBNZ     = 10;
	localparam int unsigned F_MEMW     = 11;
	localparam int unsigned F_MEMR     = 12;
	localparam int unsigned F_MEMTOREG = 13;
	localparam int unsigned F_SIZE0    = 14;
	localparam int unsigned F_SIZE1    = 15;

	localparam int unsigned IMM_W   = 28;
	localparam int unsigned FLAGS_W = 16;

	localparam logic [5:0] IMMS_ALL_ONES = 6'h3f;

	// one decoded word
	typedef struct packed {
		alu_op_t                   alu_op;
		logic signed [IMM_W-1:0]   immediate;
		logic [4:0]                src_reg_a;
		logic [4:0]                src_reg_b;
		logic [4:0]                dest_reg;
		logic [3:0]                branch_cond;
		logic [FLAGS_W-1:0]        control_flags;
	} dec_word_t;

endpackage

@@ hw/rtl/a64dec_in_if.sv @@
// ----------------------------------------------------------------------------
// a64dec_in_if
// Instruction channel into the decoder: valid/ready plus fetch word.
// ----------------------------------------------------------------------------
interface a64dec_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic        predictor_missed;

	modport source (output valid, output instr_word, output predictor_missed, input ready);
	modport sink   (input valid, input instr_word, input predictor_missed, output ready);
endinterface

@@ hw/rtl/a64dec_out_if.sv @@
// ----------------------------------------------------------------------------
// a64dec_out_if
// Decoded word channel out of the decoder: valid/ready plus control fields.
// ----------------------------------------------------------------------------
interface a64dec_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         alu_op;
	logic signed [27:0] immediate;
	logic [4:0]         src_reg_a;
	logic [4:0]         src_reg_b;
	logic [4:0]         dest_reg;
	logic [3:0]         branch_cond;
	logic [15:0]        control_flags;

	modport source (output valid, output alu_op, output immediate, output src_reg_a,
		output src_reg_b, output dest_reg, output branch_cond, output control_flags,
		input ready);
	modport sink   (input valid, input alu_op, input immediate, input src_reg_a,
		input src_reg_b, input dest_reg, input branch_cond, input control_flags,
		output ready);
endinterface

@@ hw/rtl/arm64_subset_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// arm64_subset_instruction_decoder_top
// AArch64 subset decode stage: input register, decode logic, result register.
// ----------------------------------------------------------------------------
// A word accepted into the input register moves on to the result register, which
//   drives the result channel. Throughput: one word per cycle while the consumer
//   takes results; the decode logic between the two registers is the only work.
// A word is taken while a finished result still waits: both registers stall
//   independently, so ready drops only when both stages hold words and the consumer stalls.
// Reset (arst_n low, asynchronous) empties both stages; no other state.
module arm64_subset_instruction_decoder_top
	import a64dec_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	a64dec_in_if.sink     instr,
	a64dec_out_if.source  decoded
);

	// stage 1: captured fetch word
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        missed_s1;

	// stage 2: decoded word waiting for the consumer
	logic        valid_s2;
	dec_word_t   res_s2;

	dec_word_t   dec_comb;
	logic        load_s2;
	logic        load_s1;

	// stage 2 frees when empty or drained this cycle
	assign load_s2 = ~valid_s2 | decoded.ready;
	// stage 1 can refill when empty or its word moves to stage 2
	assign instr.ready = ~valid_s1 | load_s2;
	assign load_s1 = instr.valid & instr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1   <= instr.instr_word;
			missed_s1 <= instr.predictor_missed;
		end
	end

	a64dec_decode u_decode (
		.instr_word       (word_s1),
		.predictor_missed (missed_s1),
		.decoded          (dec_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			res_s2 <= dec_comb;
		end
	end

	assign decoded.valid         = valid_s2;
	assign decoded.alu_op        = res_s2.alu_op;
	assign decoded.immediate     = res_s2.immediate;
	assign decoded.src_reg_a     = res_s2.src_reg_a;
	assign decoded.src_reg_b     = res_s2.src_reg_b;
	assign decoded.dest_reg      = res_s2.dest_reg;
	assign decoded.branch_cond   = res_s2.branch_cond;
	assign decoded.control_flags = res_s2.control_flags;

	// a word in stage 1 that moves on must appear at the output
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=> decoded.valid)
		else $error("stage 1 word lost on its way to the output");

	// back-pressure only when both stages are full and the consumer stalls
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> (valid_s1 && decoded.valid && !decoded.ready))
		else $error("input stalled with room in the pipe");

	// a condition code comes only with a conditional branch
	a_cond: assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && decoded.branch_cond != 4'd0) |-> decoded.control_flags[F_CB])
		else $error("branch condition without conditional branch flag");

	// a memory access is a load or a store, never both
	a_mem: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid |-> !(decoded.control_flags[F_MEMW] && decoded.control_flags[F_MEMR]))
		else $error("load and store flags both set");

endmodule

@@ hw/rtl/a64dec_decode.sv @@
// ----------------------------------------------------------------------------
// a64dec_decode
// Combinational decode of one instruction word into a decoded word.
// ----------------------------------------------------------------------------
module a64dec_decode
	import a64dec_pkg::*;
(
	input  logic [31:0] instr_word,
	input  logic        predictor_missed,
	output dec_word_t   decoded
);

	alu_op_t             alu;
	logic [IMM_W-1:0]    imm;
	logic [FLAGS_W-1:0]  flags;
	logic [3:0]          cond;
	logic [2:0]          top;
	logic [5:0]          imms;
	logic [5:0]          immr;
	logic [IMM_W-1:0]    imm_cbr;   // 19-bit word offset, in bytes
	logic [IMM_W-1:0]    imm_ub;    // 26-bit word offset, in bytes
	logic [IMM_W-1:0]    imm_ldst;

	assign top   = instr_word[31:29];
	assign imms  = instr_word[15:10];
	assign immr  = instr_word[21:16];

	assign imm_cbr  = {{(IMM_W-21){instr_word[23]}}, instr_word[23:5], 2'b00};
	assign imm_ub   = {instr_word[25:0], 2'b00};
	assign imm_ldst = {{(IMM_W-9){instr_word[20]}}, instr_word[20:12]};

	always_comb begin
		alu   = ALU_NONE;
		imm   = '0;
		flags = '0;
		cond  = '0;
		flags[F_BTBHIT] = ~predictor_missed;

		if (instr_word[28:26] == 3'b100) begin
			// data processing, immediate
			flags[F_IMMSRC] = 1'b1;
			flags[F_REGW]   = 1'b1;
			if (instr_word[25:24] == 2'b01) begin
				alu = instr_word[30] ? ALU_SUB : ALU_ADD;
				flags[F_SETFLAGS] = instr_word[29];
				imm = {{(IMM_W-12){1'b0}}, instr_word[21:10]};
			end else if (instr_word[25:23] == 3'b101) begin
				alu = ALU_MOV;
				imm = {{(IMM_W-16){1'b0}}, instr_word[20:5]};
			end else if (instr_word[25:23] == 3'b110) begin
				if (imms == IMMS_ALL_ONES) begin
					alu = ALU_LSR;
					imm = {{(IMM_W-6){1'b0}}, immr};
				end else if ({1'b0, imms} + 7'd1 == {1'b0, immr}) begin
					alu = ALU_LSL;
					imm = {{(IMM_W-6){1'b0}}, ~imms};
				end
			end
		end else if (instr_word[28:26] == 3'b101) begin
			// branches and system
			if (top == 3'b110) begin
				if (instr_word[25:24] == 2'b00) begin
					flags[F_HALT] = 1'b1;
				end else if (instr_word[25]) begin
					flags[F_UB]    = 1'b1;
					flags[F_PCREG] = 1'b1;
				end
			end else if (top == 3'b010 && !instr_word[25]) begin
				flags[F_CB] = 1'b1;
				cond = instr_word[3:0];
				imm  = imm_cbr;
			end else if (top[1:0] == 2'b00) begin
				flags[F_UB] = 1'b1;
				imm = imm_ub;
			end else if (top[1:0] == 2'b01 && !instr_word[25]) begin
				flags[F_CB]      = 1'b1;
				flags[F_ALUZERO] = 1'b1;
				flags[F_B2DEST]  = 1'b1;
				flags[F_CBNZ]    = instr_word[24];
				alu = ALU_TSTZ;
				imm = imm_cbr;
			end
		end else if (!instr_word[25] && instr_word[27]) begin
			// loads and stores, unscaled immediate
			imm = imm_ldst;
			flags[F_IMMSRC] = 1'b1;
			alu = ALU_ADD;
			if (instr_word[29:28] == 2'b11 && !instr_word[24] && !instr_word[21] &&
				instr_word[11:10] == 2'b00) begin
				case (instr_word[23:22])
					2'b00: begin
						flags[F_MEMW]   = 1'b1;
						flags[F_B2DEST] = 1'b1;
					end
					2'b01: begin
						flags[F_MEMR]     = 1'b1;
						flags[F_MEMTOREG] = 1'b1;
						flags[F_REGW]     = 1'b1;
					end
					default: ;
				endcase
				flags[F_SIZE0] = instr_word[30];
				flags[F_SIZE1] = instr_word[31];
			end
		end else if (instr_word[27:25] == 3'b101) begin
			// data processing, register
			flags[F_REGW] = 1'b1;
			if (!instr_word[28]) begin
				if (!instr_word[24]) begin
					case (instr_word[30:29])
						2'b01:   alu = ALU_OR;
						2'b10:   alu = ALU_XOR;
						default: alu = ALU_AND;
					endcase
					flags[F_SETFLAGS] = (instr_word[30:29] == 2'b11);
				end else begin
					alu = instr_word[30] ? ALU_SUB : ALU_ADD;
					flags[F_SETFLAGS] = instr_word[29];
					imm = {{(IMM_W-12){1'b0}}, instr_word[21:10]};
				end
			end else if (instr_word[24]) begin
				alu = ALU_MUL;
			end
		end
	end

	always_comb begin
		decoded.alu_op        = alu;
		decoded.immediate     = imm;
		decoded.src_reg_a     = instr_word[9:5];
		decoded.src_reg_b     = flags[F_B2DEST] ? instr_word[4:0] : instr_word[20:16];
		decoded.dest_reg      = instr_word[4:0];
		decoded.branch_cond   = cond;
		decoded.control_flags = flags;
	end

endmodule

@@ bench/a64dec_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// a64dec_enc_pkg
// Instruction encoding fields used to build and to predict decoder words.
// ----------------------------------------------------------------------------
package a64dec_enc_pkg;

	// bits 28:26 of the word select the top-level group
	localparam logic [2:0] PAT_DP_IMM = 3'b100;
	localparam logic [2:0] PAT_BRANCH = 3'b101;
	// bits 27:25 for data processing, register forms
	localparam logic [2:0] PAT_DP_REG = 3'b101;

	// data processing immediate: class in bits 25:23, add/sub in bits 25:24
	localparam logic [1:0] CLS_ADDSUB   = 2'b01;
	localparam logic [2:0] CLS_MOVZ     = 3'b101;
	localparam logic [2:0] CLS_BITFIELD = 3'b110;

	localparam logic [4:0] PAT_ADDSUB_IMM = {PAT_DP_IMM, CLS_ADDSUB};
	localparam logic [5:0] PAT_MOVZ       = {PAT_DP_IMM, CLS_MOVZ};
	localparam logic [5:0] PAT_BITFIELD   = {PAT_DP_IMM, CLS_BITFIELD};

	// branch group: bits 31:29
	localparam logic [2:0] TOP_SYS   = 3'b110;
	localparam logic [2:0] TOP_BCOND = 3'b010;
	// bits 30:29 only
	localparam logic [1:0] TOP_B     = 2'b00;
	localparam logic [1:0] TOP_CB    = 2'b01;

	// load/store unscaled: bits 29:27, opc in bits 23:22
	localparam logic [2:0] PAT_LDST  = 3'b111;
	localparam logic [1:0] LS_STORE  = 2'b00;
	localparam logic [1:0] LS_LOAD   = 2'b01;
	localparam logic [1:0] LS_NOMEM  = 2'b10;

	// bits 28:24 of register forms
	localparam logic [4:0] PAT_LOGICAL    = 5'b01010;
	localparam logic [4:0] PAT_ADDSUB_REG = 5'b01011;
	localparam logic [4:0] PAT_MUL        = 5'b11011;

	// logical opc, bits 30:29
	localparam logic [1:0] LOG_AND  = 2'b00;
	localparam logic [1:0] LOG_ORR  = 2'b01;
	localparam logic [1:0] LOG_EOR  = 2'b10;
	localparam logic [1:0] LOG_ANDS = 2'b11;

endpackage

@@ bench/decode_checker.sv @@
// ----------------------------------------------------------------------------
// decode_checker
// Watches both decoder channels, predicts each decoded word and compares.
// ----------------------------------------------------------------------------
module decode_checker
	import a64dec_pkg::*;
	import a64dec_enc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	a64dec_in_if         instr,
	a64dec_out_if        decoded,
	output int unsigned  mismatches,
	output int unsigned  outstanding
);

	localparam int unsigned MAX_REPORTS = 10;

	typedef struct {
		logic [31:0] word;
		dec_word_t   want;
	} pending_decode_t;

	pending_decode_t decode_queue[$];

	function automatic dec_word_t predict_decode(input logic [31:0] w, input logic missed);
		dec_word_t        d;
		logic [15:0]      fl;
		alu_op_t          alu;
		logic [IMM_W-1:0] imm;
		logic [3:0]       cond;
		logic [2:0]       top;
		logic [3:0]       sub;
		logic [5:0]       imms;
		logic [5:0]       immr;
		logic [5:0]       shl;
		logic [1:0]       opc;
		fl   = '0;
		alu  = ALU_NONE;
		imm  = '0;
		cond = '0;
		fl[F_BTBHIT] = !missed;
		if (w[28:26] == PAT_DP_IMM) begin
			fl[F_IMMSRC] = 1'b1;
			fl[F_REGW]   = 1'b1;
			if (w[25:24] == CLS_ADDSUB) begin
				alu = w[30] ? ALU_SUB : ALU_ADD;
				fl[F_SETFLAGS] = w[29];
				imm = {16'd0, w[21:10]};      // sh bit ignored
			end else if (w[25:23] == CLS_MOVZ) begin
				alu = ALU_MOV;
				imm = {12'd0, w[20:5]};       // hw ignored
			end else if (w[25:23] == CLS_BITFIELD) begin
				imms = w[15:10];
				immr = w[21:16];
				shl  = ~imms;
				if (imms == IMMS_ALL_ONES) begin
					alu = ALU_LSR;
					imm = {22'd0, immr};
				end else if ({1'b0, imms} + 7'd1 == {1'b0, immr}) begin
					alu = ALU_LSL;
					imm = {22'd0, shl};
				end
			end
		end else if (w[28:26] == PAT_BRANCH) begin
			top = w[31:29];
			sub = w[25:22];
			if (top == TOP_SYS) begin
				if (sub[3:2] == 2'b00) begin
					fl[F_HALT] = 1'b1;
				end else if (sub[3]) begin
					fl[F_UB]    = 1'b1;
					fl[F_PCREG] = 1'b1;
				end
			end else if (top == TOP_BCOND && !sub[3]) begin
				fl[F_CB] = 1'b1;
				cond = w[3:0];
				imm  = {{7{w[23]}}, w[23:5], 2'b00};
			end else if (top[1:0] == TOP_B) begin
				fl[F_UB] = 1'b1;
				imm = {w[25:0], 2'b00};
			end else if (top[1:0] == TOP_CB && !sub[3]) begin
				fl[F_CB]      = 1'b1;
				fl[F_ALUZERO] = 1'b1;
				fl[F_B2DEST]  = 1'b1;
				fl[F_CBNZ]    = w[24];
				alu = ALU_TSTZ;
				imm = {{7{w[23]}}, w[23:5], 2'b00};
			end
		end else if (!w[25] && w[27]) begin
			// load/store group: offset and add reported for every member
			imm = {{19{w[20]}}, w[20:12]};
			fl[F_IMMSRC] = 1'b1;
			alu = ALU_ADD;
			if (w[29:28] == PAT_LDST[1:0] && !w[24] && !w[21] && w[11:10] == 2'b00) begin
				opc = w[23:22];
				if (opc == LS_STORE) begin
					fl[F_MEMW]   = 1'b1;
					fl[F_B2DEST] = 1'b1;
				end else if (opc == LS_LOAD) begin
					fl[F_MEMR]     = 1'b1;
					fl[F_MEMTOREG] = 1'b1;
					fl[F_REGW]     = 1'b1;
				end
				fl[F_SIZE0] = w[30];
				fl[F_SIZE1] = w[31];
			end
		end else if (w[27:25] == PAT_DP_REG) begin
			fl[F_REGW] = 1'b1;
			if (!w[28]) begin
				if (!w[24]) begin
					opc = w[30:29];
					case (opc)
						LOG_ORR: alu = ALU_OR;
						LOG_EOR: alu = ALU_XOR;
						default: alu = ALU_AND;
					endcase
					fl[F_SETFLAGS] = (opc == LOG_ANDS);
				end else begin
					alu = w[30] ? ALU_SUB : ALU_ADD;
					fl[F_SETFLAGS] = w[29];
					imm = {16'd0, w[21:10]};
				end
			end else if (w[24]) begin
				alu = ALU_MUL;
			end
		end
		d.alu_op        = alu;
		d.immediate     = imm;
		d.src_reg_a     = w[9:5];
		d.src_reg_b     = fl[F_B2DEST] ? w[4:0] : w[20:16];
		d.dest_reg      = w[4:0];
		d.branch_cond   = cond;
		d.control_flags = fl;
		return d;
	endfunction

	function automatic string show_word(input dec_word_t d);
		return $sformatf("op=%0d imm=%0d a=%0d b=%0d d=%0d cond=%0d flags=%04h",
			d.alu_op, d.immediate, d.src_reg_a, d.src_reg_b, d.dest_reg,
			d.branch_cond, d.control_flags);
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	// pre-edge values are seen here: block outputs and bench drives settle elsewhere
	always @(posedge clk) begin : observe
		pending_decode_t head;
		pending_decode_t entry;
		dec_word_t       got;
		if (arst_n) begin
			if (decoded.valid && decoded.ready) begin
				got.alu_op        = alu_op_t'(decoded.alu_op);
				got.immediate     = decoded.immediate;
				got.src_reg_a     = decoded.src_reg_a;
				got.src_reg_b     = decoded.src_reg_b;
				got.dest_reg      = decoded.dest_reg;
				got.branch_cond   = decoded.branch_cond;
				got.control_flags = decoded.control_flags;
				if (decode_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected decoded word: %s", show_word(got));
				end else begin
					head = decode_queue.pop_front();
					if (got.alu_op !== head.want.alu_op ||
						got.immediate !== head.want.immediate ||
						got.src_reg_a !== head.want.src_reg_a ||
						got.src_reg_b !== head.want.src_reg_b ||
						got.dest_reg !== head.want.dest_reg ||
						got.branch_cond !== head.want.branch_cond ||
						got.control_flags !== head.want.control_flags) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch on %h\n  expected %s\n  actual   %s",
								head.word, show_word(head.want), show_word(got));
					end
				end
			end
			if (instr.valid && instr.ready) begin
				entry.word = instr.instr_word;
				entry.want = predict_decode(instr.instr_word, instr.predictor_missed);
				decode_queue.push_back(entry);
			end
			outstanding = decode_queue.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives instruction words into the subset decoder with random pacing on
// both channels; a checker beside the block predicts every decoded word.
// ----------------------------------------------------------------------------
module testbench;
	import a64dec_pkg::*;
	import a64dec_enc_pkg::*;

	localparam int unsigned RESET_CYCLES  = 10;
	localparam int unsigned NUM_RANDOM    = 1125;
	localparam int unsigned QUIET_ITEMS   = 150;   // tail of the run with no idling
	localparam int unsigned DRAIN_CYCLES  = 8;     // margin for stray output after the last expected word
	localparam int unsigned STALL_LIMIT   = 400;   // idle cycles on both channels before the run is stopped

	// random word shapes; the *_ANY kinds keep only the group bits
	typedef enum int {
		KIND_ADDSUB_IMM,
		KIND_MOVZ,
		KIND_BITFIELD,
		KIND_DP_IMM_ANY,
		KIND_SYSTEM,
		KIND_BCOND,
		KIND_B,
		KIND_CB,
		KIND_BRANCH_ANY,
		KIND_LDST,
		KIND_LOGICAL,
		KIND_ADDSUB_REG,
		KIND_MUL,
		KIND_DP_REG_ANY,
		KIND_NOISE
	} word_kind_t;

	// Directed words: field extremes, every ALU op and each odd corner.
	localparam logic [31:0] DIRECTED [26] = '{
		32'h0000_0000,
		32'hFFFF_FFFF,
		// add imm, largest imm12
		{1'b1, 2'b00, PAT_ADDSUB_IMM, 1'b0, 1'b0, 12'hfff, 5'd2, 5'd1},
		// subs imm with sh set: shift must not apply
		{1'b1, 2'b11, PAT_ADDSUB_IMM, 1'b0, 1'b1, 12'h001, 5'd31, 5'd31},
		// movz, hw nonzero, full imm16
		{1'b1, 2'b10, PAT_MOVZ, 2'b11, 16'hffff, 5'd7},
		// lsr: imms all ones
		{1'b1, 2'b10, PAT_BITFIELD, 1'b1, 6'd5, 6'h3f, 5'd3, 5'd4},
		// lsl at the top end of immr
		{1'b0, 2'b10, PAT_BITFIELD, 1'b0, 6'd63, 6'd62, 5'd31, 5'd31},
		// bitfield that is neither shift
		{1'b1, 2'b10, PAT_BITFIELD, 1'b1, 6'd2, 6'd10, 5'd6, 5'd6},
		// b, most positive and bl most negative offset
		{1'b0, TOP_B, PAT_BRANCH, 26'h1ff_ffff},
		{1'b1, TOP_B, PAT_BRANCH, 26'h200_0000},
		// b.cond, both offset extremes
		{TOP_BCOND, PAT_BRANCH, 2'b00, 19'h3ffff, 1'b0, 4'hf},
		{TOP_BCOND, PAT_BRANCH, 2'b00, 19'h40000, 1'b0, 4'h0},
		// cbz / cbnz
		{1'b1, TOP_CB, PAT_BRANCH, 1'b0, 1'b0, 19'h7ffff, 5'd9},
		{1'b0, TOP_CB, PAT_BRANCH, 1'b0, 1'b1, 19'h00001, 5'd31},
		32'hD61F_00A0,     // br x5
		32'hD440_0000,     // hlt #0
		// stur / ldur, opc with no memory access, and a broken ldur
		{2'b11, PAT_LDST, 1'b0, 2'b00, LS_STORE, 1'b0, 9'h100, 2'b00, 5'd1, 5'd2},
		{2'b01, PAT_LDST, 1'b0, 2'b00, LS_LOAD, 1'b0, 9'h0ff, 2'b00, 5'd31, 5'd3},
		{2'b10, PAT_LDST, 1'b1, 2'b00, LS_NOMEM, 1'b0, 9'h055, 2'b00, 5'd4, 5'd5},
		{2'b11, PAT_LDST, 1'b0, 2'b00, LS_LOAD, 1'b0, 9'h1ff, 2'b01, 5'd6, 5'd7},
		// logical: and, orr, eor, ands
		{1'b1, LOG_AND, PAT_LOGICAL, 2'b00, 1'b0, 5'd3, 6'd0, 5'd2, 5'd1},
		{1'b1, LOG_ORR, PAT_LOGICAL, 2'b00, 1'b0, 5'd4, 6'd1, 5'd5, 5'd6},
		{1'b0, LOG_EOR, PAT_LOGICAL, 2'b11, 1'b1, 5'd31, 6'h3f, 5'd31, 5'd0},
		{1'b1, LOG_ANDS, PAT_LOGICAL, 2'b01, 1'b0, 5'd8, 6'd9, 5'd10, 5'd11},
		// add reg: imm field carries bits 21:10
		{1'b0, 2'b00, PAT_ADDSUB_REG, 2'b00, 1'b0, 5'd17, 6'h3f, 5'd2, 5'd1},
		// mul (madd)
		{1'b1, 2'b00, PAT_MUL, 3'b000, 5'd3, 1'b0, 5'd31, 5'd2, 5'd1}
	};

	logic        clk;
	logic        arst_n;
	bit          quiet_tail;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned src_stretch;
	bit          src_calm;
	int unsigned idle_cycles;

	a64dec_in_if  instr_ch ();
	a64dec_out_if dec_ch ();

	arm64_subset_instruction_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr_ch),
		.decoded (dec_ch)
	);

	decode_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr_ch),
		.decoded     (dec_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Random instruction of the given shape; fields not pinned stay random.
	function automatic logic [31:0] shape_word(input word_kind_t kind);
		logic [31:0] w;
		w = $urandom;
		case (kind)
			KIND_ADDSUB_IMM: w[28:24] = PAT_ADDSUB_IMM;
			KIND_MOVZ:       w[28:23] = PAT_MOVZ;
			KIND_BITFIELD: begin
				w[28:23] = PAT_BITFIELD;
				// steer toward lsr and lsl; a third stays arbitrary
				case ($urandom_range(0, 2))
					0: w[15:10] = IMMS_ALL_ONES;
					1: begin
						w[15:10] = 6'($urandom_range(0, 62));
						w[21:16] = w[15:10] + 6'd1;
					end
					default: ;
				endcase
			end
			KIND_DP_IMM_ANY: w[28:26] = PAT_DP_IMM;
			KIND_SYSTEM: begin
				w[31:29] = TOP_SYS;
				w[28:26] = PAT_BRANCH;
			end
			KIND_BCOND: begin
				w[31:29] = TOP_BCOND;
				w[28:26] = PAT_BRANCH;
				w[25]    = 1'b0;
			end
			KIND_B: begin
				w[30:29] = TOP_B;
				w[28:26] = PAT_BRANCH;
			end
			KIND_CB: begin
				w[30:29] = TOP_CB;
				w[28:26] = PAT_BRANCH;
				w[25]    = 1'b0;
			end
			KIND_BRANCH_ANY: w[28:26] = PAT_BRANCH;
			KIND_LDST: begin
				w[27] = 1'b1;
				w[25] = 1'b0;
				// mostly well-formed ldur/stur, mostly store or load opc
				if ($urandom_range(0, 3) != 0) begin
					w[29:27] = PAT_LDST;
					w[24]    = 1'b0;
					w[23]    = ($urandom_range(0, 3) == 0);
					w[21]    = 1'b0;
					w[11:10] = 2'b00;
				end
			end
			KIND_LOGICAL:    w[28:24] = PAT_LOGICAL;
			KIND_ADDSUB_REG: w[28:24] = PAT_ADDSUB_REG;
			KIND_MUL:        w[28:24] = PAT_MUL;
			KIND_DP_REG_ANY: w[27:25] = PAT_DP_REG;
			default: ;
		endcase
		return w;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	// An idle burst may come first; valid stays high between back-to-back words.
	task automatic send_word(input logic [31:0] w, input logic missed);
		int unsigned n;
		if (src_stretch == 0) begin
			src_stretch = $urandom_range(16, 96);
			src_calm    = ($urandom_range(0, 3) == 0);
		end
		src_stretch--;
		if (!quiet_tail && !src_calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 14);
			instr_ch.valid            <= 1'b0;
			instr_ch.instr_word       <= $urandom;
			instr_ch.predictor_missed <= 1'($urandom);
			repeat (n) @(negedge clk);
		end
		instr_ch.valid            <= 1'b1;
		instr_ch.instr_word       <= w;
		instr_ch.predictor_missed <= missed;
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Result side: ready drops in random bursts inside busy stretches.
	initial begin : sink_pacing
		int unsigned stretch;
		int unsigned n;
		bit          calm;
		stretch = 0;
		calm    = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(16, 96);
				calm    = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				dec_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				dec_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: consecutive cycles with no word moving on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((instr_ch.valid && instr_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		word_kind_t kind;
		// every block input known from time zero
		arst_n                    = 1'b0;
		instr_ch.valid            = 1'b0;
		instr_ch.instr_word       = '0;
		instr_ch.predictor_missed = 1'b0;
		dec_ch.ready              = 1'b0;
		quiet_tail                = 1'b0;
		src_stretch               = 0;
		src_calm                  = 1'b1;
		idle_cycles               = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part; the missed bit alternates
		foreach (DIRECTED[j])
			send_word(DIRECTED[j], 1'(j));

		// random part: shaped words plus some pure noise
		for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
			quiet_tail = (i >= NUM_RANDOM - QUIET_ITEMS);
			kind = word_kind_t'($urandom_range(0, KIND_NOISE));
			send_word(shape_word(kind), 1'($urandom));
		end
		instr_ch.valid <= 1'b0;

		// wait out every expected word, then a margin for stray output
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
